// File: rtl/wildcard_name_match_core_defines.svh
// Assertion macros shared by the checker file.
`ifndef WILDCARD_NAME_MATCH_CORE_DEFINES_SVH
`define WILDCARD_NAME_MATCH_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define WNM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wildcard_name_match_core: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define WNM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wildcard_name_match_core: assertion failed");

`endif

// File: rtl/wnm_pkg.sv
package wnm_pkg;

    localparam int MAX_LEN    = 32;
    localparam int LEN_W      = $clog2(MAX_LEN + 1);
    localparam int IDX_W      = $clog2(MAX_LEN);
    localparam int KIND_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int OUT_DATA_W = 8;
    localparam int MAIL_LEN   = 6;
    localparam int MAIL_POS_W = 3;

    localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;
    localparam logic [BYTE_W-1:0] MAIL_MARK = 8'hFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_NAME       = 2'd0,
        KIND_PATTERN    = 2'd1,
        KIND_EVAL       = 2'd2,
        KIND_CLEAR_NAME = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_READ,
        ST_CMP,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic advance;
        logic next_base;
        logic finish;
        logic hit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic imm_done;
        logic imm_hit;
        logic eq;
        logic last_char;
        logic last_base;
        logic out_free;
    } status_t;

    // the bytes of "/FIDO/"
    function automatic logic [BYTE_W-1:0] mail_byte(input logic [MAIL_POS_W-1:0] pos);
        logic [BYTE_W-1:0] b;
        unique case (pos)
            3'd0:    b = 8'h2F;
            3'd1:    b = 8'h46;
            3'd2:    b = 8'h49;
            3'd3:    b = 8'h44;
            3'd4:    b = 8'h4F;
            3'd5:    b = 8'h2F;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/wnm_datapath.sv
module wnm_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    input  logic [wnm_pkg::KIND_W-1:0]      s_kind,
    input  logic [wnm_pkg::BYTE_W-1:0]      s_byte,
    input  wnm_pkg::cmd_t                   cmd,
    output wnm_pkg::status_t                status,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_matched,
    output logic                            m_overflow
);

    localparam int LEN_W  = wnm_pkg::LEN_W;
    localparam int IDX_W  = wnm_pkg::IDX_W;
    localparam int BYTE_W = wnm_pkg::BYTE_W;

    logic [BYTE_W-1:0] name_mem [wnm_pkg::MAX_LEN];
    logic [BYTE_W-1:0] pat_mem  [wnm_pkg::MAX_LEN];

    logic [LEN_W-1:0]  name_len_reg, name_len_next;
    logic              name_long_reg, name_long_next;
    logic [LEN_W-1:0]  pat_len_reg, pat_len_next;
    logic              pat_long_reg, pat_long_next;
    logic              mode_reg;

    logic              name_ff_reg, pat_head_reg, pat_tail_reg, pat_mail_reg;

    logic [LEN_W-1:0]  m_reg, base_reg, last_base_reg, j_reg;
    logic              poff_reg;
    logic [BYTE_W-1:0] rd_name_reg, rd_pat_reg;

    logic              out_valid_reg, matched_reg, overflow_reg;

    wnm_pkg::kind_t    kind;
    logic              name_we, pat_we;
    logic              ovf;

    logic              imm_done, imm_hit, poff_calc;
    logic [LEN_W-1:0]  m_calc, b0_calc, blast_calc;

    logic [LEN_W-1:0]  name_sum, pat_sum;

    assign kind    = wnm_pkg::kind_t'(s_kind);
    assign name_we = cmd.load && (kind == wnm_pkg::KIND_NAME) && (s_byte != '0)
                     && (name_len_reg < LEN_W'(wnm_pkg::MAX_LEN));
    assign pat_we  = cmd.load && (kind == wnm_pkg::KIND_PATTERN) && (s_byte != '0)
                     && (pat_len_reg < LEN_W'(wnm_pkg::MAX_LEN));
    assign ovf     = name_long_reg || pat_long_reg;

    // lengths and overflow flags
    always_comb begin
        name_len_next  = name_len_reg;
        name_long_next = name_long_reg;
        pat_len_next   = pat_len_reg;
        pat_long_next  = pat_long_reg;
        if (cmd.load) begin
            case (kind)
                wnm_pkg::KIND_NAME: begin
                    if (s_byte != '0) begin
                        if (name_we) begin
                            name_len_next = name_len_reg + LEN_W'(1);
                        end else begin
                            name_long_next = 1'b1;
                        end
                    end
                end
                wnm_pkg::KIND_PATTERN: begin
                    if (s_byte != '0) begin
                        if (pat_we) begin
                            pat_len_next = pat_len_reg + LEN_W'(1);
                        end else begin
                            pat_long_next = 1'b1;
                        end
                    end
                end
                wnm_pkg::KIND_CLEAR_NAME: begin
                    name_len_next  = '0;
                    name_long_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
        if (cmd.finish) begin
            pat_len_next  = '0;
            pat_long_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_len_reg  <= '0;
            name_long_reg <= 1'b0;
            pat_len_reg   <= '0;
            pat_long_reg  <= 1'b0;
            mode_reg      <= 1'b0;
        end else begin
            name_len_reg  <= name_len_next;
            name_long_reg <= name_long_next;
            pat_len_reg   <= pat_len_next;
            pat_long_reg  <= pat_long_next;
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    // per-string marks, kept up to date as bytes arrive
    always_ff @(posedge aclk) begin
        if (name_we && (name_len_reg == '0)) begin
            name_ff_reg <= (s_byte == wnm_pkg::MAIL_MARK);
        end
        if (pat_we) begin
            pat_tail_reg <= (s_byte == wnm_pkg::STAR_BYTE);
            if (pat_len_reg == '0) begin
                pat_head_reg <= (s_byte == wnm_pkg::STAR_BYTE);
                pat_mail_reg <= (s_byte == wnm_pkg::mail_byte('0));
            end else if (pat_len_reg < LEN_W'(wnm_pkg::MAIL_LEN)) begin
                pat_mail_reg <= pat_mail_reg && (s_byte ==
                    wnm_pkg::mail_byte(pat_len_reg[wnm_pkg::MAIL_POS_W-1:0]));
            end
        end
    end

    // byte stores, one write and one registered read each
    assign name_sum = base_reg + j_reg;
    assign pat_sum  = {{(LEN_W-1){1'b0}}, poff_reg} + j_reg;

    always_ff @(posedge aclk) begin
        if (name_we) begin
            name_mem[name_len_reg[IDX_W-1:0]] <= s_byte;
        end
        rd_name_reg <= name_mem[name_sum[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (pat_we) begin
            pat_mem[pat_len_reg[IDX_W-1:0]] <= s_byte;
        end
        rd_pat_reg <= pat_mem[pat_sum[IDX_W-1:0]];
    end

    // decide what can be settled without a scan, else set up the window
    always_comb begin
        imm_done   = 1'b1;
        imm_hit    = 1'b0;
        m_calc     = pat_len_reg;
        poff_calc  = 1'b0;
        b0_calc    = '0;
        blast_calc = '0;
        if (ovf) begin
            imm_hit = 1'b0;
        end else if (pat_len_reg == '0) begin
            imm_hit = (name_len_reg == '0);
        end else if (mode_reg && (name_len_reg != '0) && name_ff_reg
                     && (pat_len_reg == LEN_W'(wnm_pkg::MAIL_LEN)) && pat_mail_reg) begin
            imm_hit = 1'b1;
        end else if (pat_head_reg && pat_tail_reg) begin
            m_calc    = pat_len_reg - LEN_W'(2);
            poff_calc = 1'b1;
            if (pat_len_reg <= LEN_W'(2)) begin
                // lone star, or two stars round nothing
                imm_hit = 1'b1;
            end else if (m_calc > name_len_reg) begin
                imm_hit = 1'b0;
            end else begin
                imm_done   = 1'b0;
                blast_calc = name_len_reg - m_calc;
            end
        end else if (pat_head_reg) begin
            m_calc    = pat_len_reg - LEN_W'(1);
            poff_calc = 1'b1;
            if (name_len_reg >= m_calc) begin
                imm_done   = 1'b0;
                b0_calc    = name_len_reg - m_calc;
                blast_calc = name_len_reg - m_calc;
            end
        end else if (pat_tail_reg) begin
            m_calc = pat_len_reg - LEN_W'(1);
            if (name_len_reg >= m_calc) begin
                imm_done = 1'b0;
            end
        end else begin
            if (name_len_reg == pat_len_reg) begin
                imm_done = 1'b0;
            end
        end
    end

    // scan counters
    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            m_reg         <= m_calc;
            poff_reg      <= poff_calc;
            base_reg      <= b0_calc;
            last_base_reg <= blast_calc;
            j_reg         <= '0;
        end else if (cmd.next_base) begin
            base_reg <= base_reg + LEN_W'(1);
            j_reg    <= '0;
        end else if (cmd.advance) begin
            j_reg <= j_reg + LEN_W'(1);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            matched_reg  <= cmd.hit && !ovf;
            overflow_reg <= ovf;
        end
    end

    assign status.imm_done  = imm_done;
    assign status.imm_hit   = imm_hit;
    assign status.eq        = (rd_name_reg == rd_pat_reg);
    assign status.last_char = (j_reg == (m_reg - LEN_W'(1)));
    assign status.last_base = (base_reg == last_base_reg);
    assign status.out_free  = !out_valid_reg || m_ready;

    assign m_valid    = out_valid_reg;
    assign m_matched  = matched_reg;
    assign m_overflow = overflow_reg;

endmodule

// File: rtl/wnm_ctrl.sv
module wnm_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic [wnm_pkg::KIND_W-1:0]  s_kind,
    output logic                        s_ready,
    input  wnm_pkg::status_t            status,
    output wnm_pkg::cmd_t               cmd
);

    wnm_pkg::state_t state_reg, state_next;
    logic            hit_reg, hit_next;
    logic            accept;

    assign s_ready = (state_reg == wnm_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wnm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg <= hit_next;
    end

    always_comb begin
        state_next    = state_reg;
        hit_next      = hit_reg;
        cmd           = '0;
        cmd.load      = accept;
        cmd.hit       = hit_reg;
        unique case (state_reg)
            wnm_pkg::ST_IDLE: begin
                if (accept && (wnm_pkg::kind_t'(s_kind) == wnm_pkg::KIND_EVAL)) begin
                    state_next = wnm_pkg::ST_PREP;
                end
            end
            wnm_pkg::ST_PREP: begin
                cmd.prep = 1'b1;
                if (status.imm_done) begin
                    hit_next   = status.imm_hit;
                    state_next = wnm_pkg::ST_FINISH;
                end else begin
                    state_next = wnm_pkg::ST_READ;
                end
            end
            wnm_pkg::ST_READ: begin
                // store read in flight
                state_next = wnm_pkg::ST_CMP;
            end
            wnm_pkg::ST_CMP: begin
                if (status.eq) begin
                    if (status.last_char) begin
                        hit_next   = 1'b1;
                        state_next = wnm_pkg::ST_FINISH;
                    end else begin
                        cmd.advance = 1'b1;
                        state_next  = wnm_pkg::ST_READ;
                    end
                end else if (status.last_base) begin
                    hit_next   = 1'b0;
                    state_next = wnm_pkg::ST_FINISH;
                end else begin
                    cmd.next_base = 1'b1;
                    state_next    = wnm_pkg::ST_READ;
                end
            end
            wnm_pkg::ST_FINISH: begin
                // hold until the result register is free
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = wnm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wnm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/wildcard_name_match_core.sv
// Byte loads (name, pattern, clear name): one request per cycle while idle, no result.
// Evaluate request: settled in the prepare state from lengths and marks, or by
// byte compares (a read state, then a compare state) through the single read port
// of each byte store (up to (lu-m+1)*m compares for a star-enclosed pattern).
// Input is held off from an evaluate request until its result is registered.
// Reset: synchronous, active low; clears lengths, overflow flags and the mode.
module wildcard_name_match_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_wr_data,   // special_mail_mode
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [wnm_pkg::BYTE_W-1:0]        s_axis_tdata,  // [7:0] char_value
    input  logic [wnm_pkg::KIND_W-1:0]        s_axis_tuser,  // [1:0] kind
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [wnm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // [0] matched, [7:1] zero
    output logic                              m_axis_tuser   // [0] overflow
);

    wnm_pkg::cmd_t    cmd;
    wnm_pkg::status_t status;
    logic             matched;

    wnm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_kind  (s_axis_tuser),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    wnm_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_kind      (s_axis_tuser),
        .s_byte      (s_axis_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_matched   (matched),
        .m_overflow  (m_axis_tuser)
    );

    assign m_axis_tdata = {{(wnm_pkg::OUT_DATA_W-1){1'b0}}, matched};

endmodule

// File: rtl/wnm_checker.sv
`include "wildcard_name_match_core_defines.svh"

module wnm_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [wnm_pkg::KIND_W-1:0]        s_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [wnm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              m_axis_tuser
);

    logic                           eval_accept;
    logic                           out_stall;
    logic [wnm_pkg::OUT_DATA_W:0]   out_word;

    assign eval_accept = s_axis_tvalid && s_axis_tready
                         && (s_axis_tuser == wnm_pkg::KIND_EVAL);
    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign out_word    = {m_axis_tuser, m_axis_tdata};

    // a stalled result holds
    `WNM_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_axis_tvalid && $stable(out_word))

    // an overflowed evaluation never reports a match
    `WNM_ASSERT_NOW(a_ovf_no_match, aclk, aresetn, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)

    // an evaluate request blocks input for at least the next cycle
    `WNM_ASSERT_NEXT(a_eval_busy, aclk, aresetn, eval_accept, !s_axis_tready)

    // a fresh result only appears straight after the busy phase
    `WNM_ASSERT_NOW(a_rise_after_busy, aclk, aresetn, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind wildcard_name_match_core wnm_checker u_wnm_checker (.*);

// File: dv/wildcard_name_match_core_tb.sv
`timescale 1ns / 1ps

module wildcard_name_match_core_tb;
    import wnm_pkg::*;

    localparam logic [BYTE_W-1:0] CH_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_B = 8'h62;
    localparam int PHASE_REQS = 150;

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    class glob_verdicts;
        logic [BYTE_W-1:0] name_buf [MAX_LEN];
        logic [BYTE_W-1:0] pat_buf [MAX_LEN];
        logic [BYTE_W-1:0] fido_tag [MAIL_LEN];
        int name_len;
        int pat_len;
        bit name_long;
        bit pat_long;
        bit mail_mode;
        verdict_t due_verdicts[$];
        int errors;
        int checked;
        int hits;
        int overflows;

        function new();
            name_len  = 0;
            pat_len   = 0;
            name_long = 0;
            pat_long  = 0;
            mail_mode = 0;
            errors    = 0;
            checked   = 0;
            hits      = 0;
            overflows = 0;
            fido_tag  = '{8'h2F, 8'h46, 8'h49, 8'h44, 8'h4F, 8'h2F};
        endfunction

        function void set_mode(bit m);
            mail_mode = m;
        endfunction

        function int pending();
            return due_verdicts.size();
        endfunction

        function bit same_run(int name_off, int pat_off, int n);
            for (int i = 0; i < n; i++)
                if (name_buf[name_off + i] != pat_buf[pat_off + i])
                    return 0;
            return 1;
        endfunction

        function bit glob_decides();
            bit head_star;
            bit tail_star;
            bit fido;
            int m;
            if (pat_len == 0)
                return name_len == 0;
            fido = (pat_len == MAIL_LEN);
            for (int i = 0; i < MAIL_LEN && fido; i++)
                if (pat_buf[i] != fido_tag[i])
                    fido = 0;
            if (mail_mode && name_len >= 1 && name_buf[0] == MAIL_MARK && fido)
                return 1;
            head_star = pat_buf[0] == STAR_BYTE;
            tail_star = pat_buf[pat_len - 1] == STAR_BYTE;
            if (head_star && tail_star) begin
                if (pat_len < 2)
                    return 1;
                m = pat_len - 2;
                if (m > name_len)
                    return 0;
                for (int s = 0; s <= name_len - m; s++)
                    if (same_run(s, 1, m))
                        return 1;
                return 0;
            end
            if (head_star) begin
                m = pat_len - 1;
                return name_len >= m && same_run(name_len - m, 1, m);
            end
            if (tail_star) begin
                m = pat_len - 1;
                return name_len >= m && same_run(0, 0, m);
            end
            return name_len == pat_len && same_run(0, 0, pat_len);
        endfunction

        function void take_request(kind_t k, logic [BYTE_W-1:0] b);
            verdict_t v;
            case (k)
                KIND_NAME: begin
                    if (b != 0) begin
                        if (name_len < MAX_LEN) begin
                            name_buf[name_len] = b;
                            name_len++;
                        end else begin
                            name_long = 1;
                        end
                    end
                end
                KIND_PATTERN: begin
                    if (b != 0) begin
                        if (pat_len < MAX_LEN) begin
                            pat_buf[pat_len] = b;
                            pat_len++;
                        end else begin
                            pat_long = 1;
                        end
                    end
                end
                KIND_EVAL: begin
                    v.overflow = name_long || pat_long;
                    v.matched  = v.overflow ? 1'b0 : glob_decides();
                    due_verdicts.push_back(v);
                    pat_len  = 0;
                    pat_long = 0;
                end
                default: begin
                    name_len  = 0;
                    name_long = 0;
                end
            endcase
        endfunction

        function void check_verdict(logic [OUT_DATA_W-1:0] data, logic ovf);
            verdict_t want;
            if (due_verdicts.size() == 0) begin
                errors++;
                $display("%0t: unexpected verdict: expected none, got data %h overflow %b",
                         $time, data, ovf);
                return;
            end
            want = due_verdicts.pop_front();
            checked++;
            if (want.matched)
                hits++;
            if (want.overflow)
                overflows++;
            if (data[0] !== want.matched) begin
                errors++;
                $display("%0t: matched: expected %b, got %b", $time, want.matched, data[0]);
            end
            if (data[OUT_DATA_W-1:1] !== '0) begin
                errors++;
                $display("%0t: tdata padding: expected 0, got %h", $time,
                         data[OUT_DATA_W-1:1]);
            end
            if (ovf !== want.overflow) begin
                errors++;
                $display("%0t: overflow: expected %b, got %b", $time, want.overflow, ovf);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic                  cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;
    logic [KIND_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    glob_verdicts book = new();
    logic [BYTE_W-1:0] loaded_name[$];
    int sent;
    bit calm;

    wildcard_name_match_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("wildcard_name_match_core: mismatch");
        $finish;
    end

    // alternate stretches of back-to-back traffic with stretches of random gaps
    initial begin
        calm = 0;
        forever begin
            repeat ($urandom_range(40, 400)) @(posedge aclk);
            calm = ~calm;
        end
    end

    function automatic int idle_gap();
        if (calm)
            return 0;
        return $urandom_range(0, 6);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte(int alpha);
        case (alpha)
            0:       return $urandom_range(0, 1) ? CH_A : CH_B;
            1:       return ($urandom_range(0, 2) == 0) ? STAR_BYTE :
                            ($urandom_range(0, 1) ? CH_A : CH_B);
            default: return BYTE_W'($urandom_range(1, 255));
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance, valid still high
    task automatic send_request(kind_t k, logic [BYTE_W-1:0] b);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= k;
        do @(posedge aclk); while (!s_axis_tready);
        book.take_request(k, b);
        sent++;
        if (k == KIND_NAME && b != 0)
            loaded_name.push_back(b);
        else if (k == KIND_CLEAR_NAME)
            loaded_name.delete();
        @(negedge aclk);
    endtask

    // slip in an ignored zero byte now and then
    task automatic load_byte(kind_t k, logic [BYTE_W-1:0] b);
        if ($urandom_range(0, 19) == 0)
            send_request(k, 8'h00);
        send_request(k, b);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    task automatic write_mode(bit m);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        book.set_mode(m);
    endtask

    task automatic run_sequence();
        int alpha, r, nlen, n, k, s, plan;
        bit mail;
        logic [BYTE_W-1:0] pat[$];
        logic [BYTE_W-1:0] fido[MAIL_LEN];
        fido  = '{8'h2F, 8'h46, 8'h49, 8'h44, 8'h4F, 8'h2F};
        alpha = $urandom_range(0, 2);
        mail  = 0;
        if (loaded_name.size() == 0 || $urandom_range(0, 2) != 0) begin
            send_request(KIND_CLEAR_NAME, BYTE_W'($urandom_range(0, 255)));
            r = $urandom_range(0, 11);
            if (r < 8)
                nlen = $urandom_range(0, 8);
            else if (r < 11)
                nlen = $urandom_range(9, MAX_LEN);
            else
                nlen = $urandom_range(MAX_LEN + 1, MAX_LEN + 3);
            mail = nlen > 0 && $urandom_range(0, 5) == 0;
            for (int i = 0; i < nlen; i++)
                load_byte(KIND_NAME, (i == 0 && mail) ? MAIL_MARK : pick_byte(alpha));
        end
        n = loaded_name.size();
        if (n > MAX_LEN)
            n = MAX_LEN;
        plan = (mail && $urandom_range(0, 1)) ? 8 : $urandom_range(0, 9);
        case (plan)
            0, 1: begin
                for (int i = 0; i < n; i++) pat.push_back(loaded_name[i]);
            end
            2: begin
                k = $urandom_range(0, n);
                for (int i = 0; i < k; i++) pat.push_back(loaded_name[i]);
                pat.push_back(STAR_BYTE);
            end
            3: begin
                k = $urandom_range(0, n);
                pat.push_back(STAR_BYTE);
                for (int i = n - k; i < n; i++) pat.push_back(loaded_name[i]);
            end
            4, 5: begin
                k = $urandom_range(0, n);
                s = $urandom_range(0, n - k);
                pat.push_back(STAR_BYTE);
                for (int i = s; i < s + k; i++) pat.push_back(loaded_name[i]);
                pat.push_back(STAR_BYTE);
            end
            6: begin
                if ($urandom_range(0, 1))
                    pat.push_back(STAR_BYTE);
            end
            7: begin
                k = $urandom_range(0, 6);
                for (int i = 0; i < k; i++) pat.push_back(pick_byte(alpha));
            end
            8: begin
                for (int i = 0; i < MAIL_LEN; i++) pat.push_back(fido[i]);
            end
            default: begin
                k = $urandom_range(MAX_LEN + 1, MAX_LEN + 3);
                for (int i = 0; i < k; i++) pat.push_back(pick_byte(alpha));
            end
        endcase
        // corrupt one byte to turn some hits into near misses
        if (pat.size() > 0 && $urandom_range(0, 3) == 0)
            pat[$urandom_range(0, pat.size() - 1)] = pick_byte(alpha);
        foreach (pat[i]) load_byte(KIND_PATTERN, pat[i]);
        send_request(KIND_EVAL, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic run_noise();
        repeat ($urandom_range(3, 10))
            send_request(kind_t'(KIND_W'($urandom_range(0, 3))),
                         BYTE_W'($urandom_range(0, 255)));
        send_request(KIND_EVAL, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic run_directed();
        send_request(KIND_EVAL, 8'h00);             // empty against empty
        send_request(KIND_NAME, 8'h00);             // zero byte, dropped
        send_request(KIND_NAME, MAIL_MARK);
        send_request(KIND_NAME, CH_A);
        send_request(KIND_EVAL, 8'hFF);             // empty pattern, name present
        send_request(KIND_PATTERN, STAR_BYTE);
        send_request(KIND_EVAL, 8'h00);             // lone star
        send_request(KIND_PATTERN, STAR_BYTE);
        send_request(KIND_PATTERN, CH_A);
        send_request(KIND_EVAL, 8'h00);             // suffix
        send_request(KIND_PATTERN, MAIL_MARK);
        send_request(KIND_PATTERN, STAR_BYTE);
        send_request(KIND_EVAL, 8'h00);             // prefix
        send_request(KIND_PATTERN, STAR_BYTE);
        send_request(KIND_PATTERN, STAR_BYTE);
        send_request(KIND_EVAL, 8'h00);             // stars around nothing
        send_request(KIND_PATTERN, 8'h01);
        send_request(KIND_EVAL, 8'h00);             // exact miss
        send_request(KIND_CLEAR_NAME, 8'hFF);
        send_request(KIND_PATTERN, 8'h00);
        send_request(KIND_EVAL, 8'h00);             // empty again after clears
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_NAME;
        sent          = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (int phase = 0; phase < 4; phase++) begin
            write_mode(phase[0]);
            if (phase == 0)
                run_directed();
            while (sent < (phase + 1) * PHASE_REQS) begin
                if ($urandom_range(0, 9) == 0)
                    run_noise();
                else
                    run_sequence();
            end
        end
        s_axis_tvalid <= 1'b0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Sent %0d requests over four phases, mail rule off and on.", sent);
        $display("Checked %0d verdicts: %0d matched, %0d flagged overflow.",
                 book.checked, book.hits, book.overflows);
        if (book.errors == 0)
            $display("wildcard_name_match_core: match");
        else
            $display("wildcard_name_match_core: mismatch");
        $finish;
    end

    // result side: stall at random, check each accepted verdict
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = idle_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
            book.check_verdict(m_axis_tdata, m_axis_tuser);
            @(negedge aclk);
        end
    end

endmodule

// File: wildcard_name_match_core.f
+incdir+rtl
rtl/wnm_pkg.sv
rtl/wnm_datapath.sv
rtl/wnm_ctrl.sv
rtl/wildcard_name_match_core.sv
rtl/wnm_checker.sv
dv/wildcard_name_match_core_tb.sv
